// ===== hw/rtl/ffact_pkg.sv =====
// ffact_pkg: shared types and constants for the difference-of-squares factor search.
// Used by ffact_ctrl, ffact_datapath and fermat_factorizer; depends on nothing.

package ffact_pkg;

   localparam int unsigned IN_WIDTH  = 32;
   localparam int unsigned OUT_WIDTH = 32;

   typedef struct packed {
      logic load;       // capture request number, clear root unit
      logic root_step;  // one root bit from the next two-bit digit of the number
      logic setup;      // first candidate, residue and count
      logic step;       // one search step (k or candidate advance)
      logic publish;    // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic at_limit;   // candidate has reached (N + 1) / 2
      logic hit;        // residue is zero: candidate squared minus N is k squared
   } status_type;

endpackage

// ===== hw/rtl/ffact_ctrl.sv =====
// ffact_ctrl: sequencing state machine for the factor search.
// Depends on ffact_pkg; drives commands into ffact_datapath and owns both handshakes.

module ffact_ctrl #(
   parameter int unsigned NUMBER_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ffact_pkg::status_type  status,
   output ffact_pkg::cmd_type     cmd
);

   localparam int unsigned ROOT_STEPS = (NUMBER_WIDTH + 1) / 2;
   localparam int unsigned CNT_WIDTH  = $clog2(ROOT_STEPS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROOT,
      ST_SETUP,
      ST_SEARCH
   } state_type;

   state_type              state_ff;
   logic                   req_ready_ff;
   logic                   rsp_valid_ff;
   logic [CNT_WIDTH-1:0]   root_cnt_ff;
   logic                   root_last;
   logic                   done;
   logic                   out_free;

   assign root_last = (root_cnt_ff == CNT_WIDTH'(ROOT_STEPS - 1));
   assign done      = status.at_limit || status.hit;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == ST_IDLE) && req_valid && req_ready_ff;
      cmd.root_step = (state_ff == ST_ROOT);
      cmd.setup     = (state_ff == ST_SETUP);
      cmd.step      = (state_ff == ST_SEARCH) && !done;
      cmd.publish   = (state_ff == ST_SEARCH) && done && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         root_cnt_ff  <= '0;
      end else begin
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               root_cnt_ff <= '0;
               if (cmd.load) begin
                  req_ready_ff <= 1'b0;
                  state_ff     <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               root_cnt_ff <= root_cnt_ff + CNT_WIDTH'(1);
               if (root_last) begin
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               state_ff <= ST_SEARCH;
            end
            ST_SEARCH: begin
               if (cmd.publish) begin
                  req_ready_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/ffact_datapath.sv =====
// ffact_datapath: number capture, digit-serial square root, search registers, output register.
// Depends on ffact_pkg; commanded by ffact_ctrl.

module ffact_datapath #(
   parameter int unsigned NUMBER_WIDTH = 32
) (
   input  logic                                clock,
   input  ffact_pkg::cmd_type                  cmd,
   output ffact_pkg::status_type               status,
   input  logic [ffact_pkg::IN_WIDTH-1:0]      req_number_in,
   output logic [ffact_pkg::OUT_WIDTH-1:0]     rsp_larger_factor,
   output logic [ffact_pkg::OUT_WIDTH-1:0]     rsp_smaller_factor,
   output logic [ffact_pkg::OUT_WIDTH-1:0]     rsp_iteration_total
);

   localparam int unsigned W   = NUMBER_WIDTH;
   localparam int unsigned RW  = (W + 1) / 2;    // root digits
   localparam int unsigned SW  = 2 * RW;         // padded number
   localparam int unsigned EW  = W + 2;          // residue
   localparam int unsigned OW  = ffact_pkg::OUT_WIDTH;

   logic [W-1:0]     num_ff,    num_in;
   logic [W-1:0]     limit_ff,  limit_in;
   logic [SW-1:0]    sq_ff,     sq_in;
   logic [RW-1:0]    root_ff,   root_in;
   logic [RW:0]      rem_ff,    rem_in;
   logic [W-1:0]     cand_ff,   cand_in;
   logic [W-1:0]     kval_ff,   kval_in;
   logic [EW-1:0]    err_ff,    err_in;
   logic [W-1:0]     count_ff,  count_in;
   logic [OW-1:0]    larger_ff, smaller_ff, total_ff;

   logic [W-1:0]     n_req;
   logic [RW+2:0]    rem_sh;
   logic [RW+2:0]    trial;
   logic [EW-1:0]    k_odd;
   logic [EW-1:0]    q_odd;
   logic [EW-1:0]    first_err;
   logic             need_norm;
   logic [W-1:0]     big;
   logic [W-1:0]     small_f;

   assign n_req     = req_number_in[W-1:0];
   assign rem_sh    = {rem_ff, sq_ff[SW-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign k_odd     = EW'({kval_ff, 1'b1});
   assign q_odd     = EW'({cand_ff, 1'b1});
   assign first_err = EW'({root_ff, 1'b1}) - EW'(rem_ff);
   assign need_norm = (err_ff >= k_odd);

   assign status.at_limit = (cand_ff >= limit_ff);
   assign status.hit      = (err_ff == '0);

   assign big     = status.at_limit ? num_ff : cand_ff + kval_ff;
   assign small_f = status.at_limit ? W'(1) : cand_ff - kval_ff;

   always_comb begin
      num_in   = num_ff;
      limit_in = limit_ff;
      sq_in    = sq_ff;
      root_in  = root_ff;
      rem_in   = rem_ff;
      cand_in  = cand_ff;
      kval_in  = kval_ff;
      err_in   = err_ff;
      count_in = count_ff;
      if (cmd.load) begin
         num_in   = n_req;
         limit_in = W'(({1'b0, n_req} + (W + 1)'(1)) >> 1);
         sq_in    = SW'(n_req);
         root_in  = '0;
         rem_in   = '0;
      end
      if (cmd.root_step) begin
         sq_in = sq_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = (RW + 1)'(rem_sh - trial);
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[RW:0];
            root_in = {root_ff[RW-2:0], 1'b0};
         end
      end
      if (cmd.setup) begin
         kval_in  = '0;
         count_in = W'(1);
         if (rem_ff == '0) begin
            cand_in = W'(root_ff);
            err_in  = '0;
         end else begin
            cand_in = W'(root_ff) + W'(1);
            err_in  = first_err;
         end
      end
      if (cmd.step) begin
         if (need_norm) begin
            err_in  = err_ff - k_odd;
            kval_in = kval_ff + W'(1);
         end else begin
            err_in   = err_ff + q_odd;
            cand_in  = cand_ff + W'(1);
            count_in = count_ff + W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      limit_ff <= limit_in;
      sq_ff    <= sq_in;
      root_ff  <= root_in;
      rem_ff   <= rem_in;
      cand_ff  <= cand_in;
      kval_ff  <= kval_in;
      err_ff   <= err_in;
      count_ff <= count_in;
      if (cmd.publish) begin
         larger_ff  <= OW'(big);
         smaller_ff <= OW'(small_f);
         total_ff   <= OW'(count_ff);
      end
   end

   assign rsp_larger_factor   = larger_ff;
   assign rsp_smaller_factor  = smaller_ff;
   assign rsp_iteration_total = total_ff;

endmodule

// ===== hw/rtl/fermat_factorizer.sv =====
// fermat_factorizer: top level of the difference-of-squares factor search.
// Depends on ffact_pkg, ffact_ctrl and ffact_datapath.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_number_in
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_larger_factor, rsp_smaller_factor,
//           |           |                      | rsp_iteration_total
//
// One request at a time. After acceptance the controller runs the digit-serial square root
// (ST_ROOT), a setup state (ST_SETUP), then search steps, each a candidate advance or an
// increment of the root k (final k); publish follows and registers rsp_valid. Each search step
// is one add and compare. The output register lets the next request be taken from the cycle
// after publish while a result waits; a finished search holds until that register is free.
// Reset is synchronous; it clears the controller and output valid.

module fermat_factorizer #(
   parameter int unsigned NUMBER_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ffact_pkg::IN_WIDTH-1:0]      req_number_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ffact_pkg::OUT_WIDTH-1:0]     rsp_larger_factor,
   output logic [ffact_pkg::OUT_WIDTH-1:0]     rsp_smaller_factor,
   output logic [ffact_pkg::OUT_WIDTH-1:0]     rsp_iteration_total
);

   ffact_pkg::cmd_type     cmd;
   ffact_pkg::status_type  status;

   ffact_ctrl #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ffact_datapath #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .cmd                 (cmd),
      .status              (status),
      .req_number_in       (req_number_in),
      .rsp_larger_factor   (rsp_larger_factor),
      .rsp_smaller_factor  (rsp_smaller_factor),
      .rsp_iteration_total (rsp_iteration_total)
   );

   // one request in flight: no second acceptance right after one
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a search is running");

   // a search step is never issued once the candidate has reached the bound
   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !status.at_limit)
      else $error("search stepped past the candidate bound");

   // every published result counts at least one candidate
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_iteration_total != '0))
      else $error("result with zero iteration count");

   // a found pair is ordered
   a_pair_ordered: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_smaller_factor != ffact_pkg::OUT_WIDTH'(1)))
         |-> (rsp_smaller_factor <= rsp_larger_factor))
      else $error("factor pair out of order");

endmodule
